// ----- src/sdtt_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtt_pkg
// types, codes and the class decode shared by the seen-device tracking table
// ----------------------------------------------------------------------------
package sdtt_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TS_W    = 64;
  localparam int unsigned CLASS_W = 24;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned SLOT_W  = 6;

  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 136;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned MAJOR_SHIFT = 8;
  localparam logic [4:0]  MAJOR_MASK  = 5'h1F;

  localparam logic [TYPE_W-1:0] TYPE_NONE       = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_COMPUTER   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_PHONE      = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_AUDIO      = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_CONTROLLER = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN    = 3'd5;

  localparam logic [4:0] MAJOR_COMPUTER   = 5'd1;
  localparam logic [4:0] MAJOR_PHONE      = 5'd2;
  localparam logic [4:0] MAJOR_AUDIO      = 5'd4;
  localparam logic [4:0] MAJOR_CONTROLLER = 5'd5;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic                 mode;
    logic [ADDR_W-1:0]    addr;
    logic [TS_W-1:0]      ts;
    logic [CLASS_W-1:0]   cls;
    logic [TYPE_W-1:0]    ptype;
  } item_t;

  typedef struct packed {
    logic [TS_W-1:0]      first_seen;
    logic [CNT_W-1:0]     sight_cnt;
    logic [CLASS_W-1:0]   cls;
    logic [TYPE_W-1:0]    dtype;
  } rec_t;

  function automatic logic [TYPE_W-1:0] type_from_class(input logic [CLASS_W-1:0] cls);
    logic [4:0] major;
    major = cls[MAJOR_SHIFT +: 5] & MAJOR_MASK;
    case (major)
      MAJOR_COMPUTER:   type_from_class = TYPE_COMPUTER;
      MAJOR_PHONE:      type_from_class = TYPE_PHONE;
      MAJOR_AUDIO:      type_from_class = TYPE_AUDIO;
      MAJOR_CONTROLLER: type_from_class = TYPE_CONTROLLER;
      default:          type_from_class = TYPE_UNKNOWN;
    endcase
  endfunction

endpackage

// ----- src/seen_device_tracking_table_unit.sv -----
// ----------------------------------------------------------------------------
// seen_device_tracking_table_unit
// table of seen devices keyed by 48-bit address, updated per sighting
// ----------------------------------------------------------------------------
// Each sighting beat is decoded and queued, then the table engine scans the
// address memory one entry per cycle from slot 0 up to the occupied count,
// stopping at a hit; a finished result may wait in the update state for the
// output register to free up. The single read port of the address memory is
// why the scan goes one entry at a time. A hit updates the entry, a miss
// appends one, and a full table drops the sighting with status 2. Up to two
// further sightings are taken into the queue while one is being worked on,
// and a finished result waits in the output register without blocking the
// next search. Entries are only ever used below the occupied count, so no
// clearing pass follows reset.
module seen_device_tracking_table_unit #(
  parameter int unsigned MAX_DEVICES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mode, device_address, timestamp, device_class
  input  logic [sdtt_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, slot, seen_total, first_seen, type_code, stored_class
  output logic [sdtt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic            q_full;
  logic            push;
  sdtt_pkg::item_t push_item;
  logic            q_valid;
  logic            pop;
  sdtt_pkg::item_t pop_item;

  sdtt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  sdtt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  sdtt_back #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .pop        (pop),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- src/sdtt_front.sv -----
// ----------------------------------------------------------------------------
// sdtt_front
// unpacks an input beat, decodes the device type from the class code
// ----------------------------------------------------------------------------
module sdtt_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sdtt_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             q_full,
  output logic                             push,
  output sdtt_pkg::item_t                  push_item
);

  logic [sdtt_pkg::CLASS_W-1:0] cls;

  assign cls       = in_tdata[136:113];
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_item.mode  = in_tdata[0];
    push_item.addr  = in_tdata[48:1];
    push_item.ts    = in_tdata[112:49];
    push_item.cls   = cls;
    push_item.ptype = sdtt_pkg::type_from_class(cls);
  end

endmodule

// ----- src/sdtt_queue.sv -----
// ----------------------------------------------------------------------------
// sdtt_queue
// short fifo of decoded sightings between the front and the table engine
// ----------------------------------------------------------------------------
module sdtt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sdtt_pkg::item_t push_item,
  output logic            full,
  output logic            q_valid,
  input  logic            pop,
  output sdtt_pkg::item_t pop_item
);

  localparam int unsigned PW = $clog2(sdtt_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(sdtt_pkg::QUEUE_DEPTH + 1);

  sdtt_pkg::item_t mem_r [sdtt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(sdtt_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign pop_item = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(sdtt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(sdtt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

// ----- src/sdtt_back.sv -----
// ----------------------------------------------------------------------------
// sdtt_back
// table engine: sequential address search, entry update, result register
// ----------------------------------------------------------------------------
module sdtt_back #(
  parameter int unsigned MAX_DEVICES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  output logic                             pop,
  input  sdtt_pkg::item_t                  pop_item,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sdtt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int unsigned CW = $clog2(MAX_DEVICES + 1);
  localparam int unsigned EW = (IW > sdtt_pkg::SLOT_W) ? IW : sdtt_pkg::SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [sdtt_pkg::ADDR_W-1:0] addr_mem [MAX_DEVICES];
  sdtt_pkg::rec_t              rec_mem  [MAX_DEVICES];

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               iss_r, iss_nxt;
  logic                        pend_r, pend_nxt;
  logic [IW-1:0]               pend_idx_r, pend_idx_nxt;
  logic [IW-1:0]               slot_r, slot_nxt;
  logic                        ins_r, ins_nxt;
  logic                        full_r, full_nxt;
  sdtt_pkg::item_t             item_r;
  logic [sdtt_pkg::ADDR_W-1:0] addr_rd_r;
  sdtt_pkg::rec_t              rec_rd_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [sdtt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                        issuing;
  logic                        hit;
  logic                        fire;
  sdtt_pkg::rec_t              base;
  sdtt_pkg::rec_t              upd;
  logic [EW-1:0]               slot_ext;
  logic [sdtt_pkg::OUT_DATA_W-1:0] res;

  assign issuing    = (state_r == S_SRCH) && (iss_r < cnt_r) && !hit;
  assign hit        = pend_r && (addr_rd_r == item_r.addr);
  assign fire       = (state_r == S_UPD) && (!out_vld_r || out_tready);
  assign pop        = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // record after the sighting is applied, and the result beat built from it
  always_comb begin
    base = ins_r ? '0 : rec_rd_r;
    upd  = base;
    if (base.first_seen == '0) begin
      upd.first_seen = item_r.ts;
    end
    upd.sight_cnt = base.sight_cnt + 1'b1;
    if (!item_r.mode) begin
      upd.cls   = item_r.cls;
      upd.dtype = item_r.ptype;
    end else if (base.dtype == sdtt_pkg::TYPE_NONE) begin
      upd.dtype = sdtt_pkg::TYPE_UNKNOWN;
    end
    slot_ext = EW'(slot_r);
    res      = '0;
    if (full_r) begin
      res[1:0] = sdtt_pkg::ST_FULL;
    end else begin
      res[1:0]     = ins_r ? sdtt_pkg::ST_INSERTED : sdtt_pkg::ST_UPDATED;
      res[7:2]     = slot_ext[sdtt_pkg::SLOT_W-1:0];
      res[39:8]    = upd.sight_cnt;
      res[103:40]  = upd.first_seen;
      res[106:104] = upd.dtype;
      res[130:107] = upd.cls;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    slot_nxt     = slot_r;
    ins_nxt      = ins_r;
    full_nxt     = full_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit) begin
          slot_nxt  = pend_idx_r;
          ins_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = S_UPD;
        end else if (!issuing && !pend_r) begin
          full_nxt  = (cnt_r == CW'(MAX_DEVICES));
          ins_nxt   = (cnt_r != CW'(MAX_DEVICES));
          slot_nxt  = cnt_r[IW-1:0];
          state_nxt = S_UPD;
        end else begin
          pend_nxt     = issuing;
          pend_idx_nxt = iss_r[IW-1:0];
          iss_nxt      = iss_r + CW'(issuing);
        end
      end
      S_UPD: begin
        if (fire) begin
          out_vld_nxt = 1'b1;
          if (ins_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      iss_r     <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      ins_r     <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      iss_r     <= iss_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
      ins_r     <= ins_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    if (pop) begin
      item_r <= pop_item;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  // address and record stores
  always_ff @(posedge clk) begin
    addr_rd_r <= addr_mem[iss_r[IW-1:0]];
    rec_rd_r  <= rec_mem[pend_idx_r];
    if (fire && ins_r) begin
      addr_mem[slot_r] <= item_r.addr;
    end
    if (fire && !full_r) begin
      rec_mem[slot_r] <= upd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DEVICES))
    else $error("occupancy beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) && full_r |-> (cnt_r == CW'(MAX_DEVICES)))
    else $error("drop reported with free slots");

  a_ins_excl_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> !(ins_r && full_r))
    else $error("insert and drop together");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ins_r |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow occupancy");

endmodule
